[hw/rtl/dq_pkg.sv]
`default_nettype none

package dq_pkg;

  // default ring size
  localparam int CapacityDef = 16;

  // operation codes
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/double_ended_queue_core.sv]
`default_nettype none

// push and error results pass only the output register; a pop result passes the registered ring
// read and then the output register, and a dump streams one element per cycle along that same path
// push and no-op codes leave busy_o low; a pop or a dump holds busy_o high until its last result,
// as set by the single registered read port of the ring memory that every element read goes through
// results carry no backpressure: each is on the result ports for exactly one cycle
// reset: asynchronous, active low; the ring is empty, front slot 0, ring contents undefined
module double_ended_queue_core #(
  parameter int CAPACITY = dq_pkg::CapacityDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic        [2:0]  operation_i,
  input  wire logic signed [31:0] value_i,
  output logic                    strobe_o,
  output logic             [1:0]  status_o,
  output logic signed      [31:0] element_o,
  output logic                    last_of_run_o
);

  // ring index and occupancy widths
  localparam int IdxW = $clog2(CAPACITY);
  localparam int OccW = $clog2(CAPACITY + 1);
  localparam logic [IdxW:0]   CapS     = (IdxW + 1)'(CAPACITY);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(CAPACITY - 1);
  localparam logic [OccW-1:0] CapOcc   = OccW'(CAPACITY);

  // sequencer and ring bookkeeping
  dq_pkg::state_e   state_q, state_d;
  logic [IdxW-1:0]  front_q, front_d;
  logic [OccW-1:0]  occ_q, occ_d;
  logic [OccW-1:0]  cnt_q, cnt_d;

  // output register
  logic                  strobe_q, strobe_d;
  dq_pkg::status_e       status_q, status_d;
  logic signed [31:0]    elem_q, elem_d;
  logic                  last_q, last_d;

  // ring memory, one write and one registered read per cycle
  logic signed [31:0] mem_q [CAPACITY];
  logic signed [31:0] rd_q;
  logic [IdxW-1:0]    rd_addr;
  logic [IdxW-1:0]    wr_addr;
  logic               wr_en;

  logic accept;
  logic full;
  logic empty;

  // slot of the element at a given distance from the front, wrapped once
  function automatic logic [IdxW-1:0] slot_of(logic [IdxW-1:0] front, logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, front} + {1'b0, off};
    if (sum >= CapS) begin
      sum = sum - CapS;
    end
    return sum[IdxW-1:0];
  endfunction

  assign accept = start_i && (state_q == dq_pkg::S_IDLE);
  assign full   = (occ_q == CapOcc);
  assign empty  = (occ_q == '0);

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    occ_d    = occ_q;
    cnt_d    = cnt_q;
    strobe_d = 1'b0;
    status_d = dq_pkg::ST_OK;
    elem_d   = '0;
    last_d   = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = front_q;
    rd_addr  = front_q;

    case (state_q)
      dq_pkg::S_IDLE: begin
        if (accept) begin
          case (dq_pkg::op_e'(operation_i))
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
              strobe_d = 1'b1;
              last_d   = 1'b1;
              if (full) begin
                status_d = dq_pkg::ST_OVERFLOW;
              end else begin
                wr_en = 1'b1;
                occ_d = occ_q + 1'b1;
                if (operation_i == dq_pkg::OP_PUSH_FRONT) begin
                  // step the front back one slot and write there
                  front_d = (front_q == '0) ? LastSlot : front_q - 1'b1;
                  wr_addr = front_d;
                end else begin
                  wr_addr = slot_of(front_q, occ_q[IdxW-1:0]);
                end
              end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
              if (empty) begin
                strobe_d = 1'b1;
                last_d   = 1'b1;
                status_d = dq_pkg::ST_UNDERFLOW;
              end else begin
                // read issued now, result leaves from S_POP
                occ_d   = occ_q - 1'b1;
                state_d = dq_pkg::S_POP;
                if (operation_i == dq_pkg::OP_POP_FRONT) begin
                  rd_addr = front_q;
                  front_d = (front_q == LastSlot) ? '0 : front_q + 1'b1;
                end else begin
                  rd_addr = slot_of(front_q, occ_d[IdxW-1:0]);
                end
              end
            end
            dq_pkg::OP_DUMP: begin
              if (empty) begin
                strobe_d = 1'b1;
                last_d   = 1'b1;
                status_d = dq_pkg::ST_UNDERFLOW;
              end else begin
                // first element read here, the rest are read while streaming
                rd_addr = front_q;
                cnt_d   = OccW'(1);
                state_d = dq_pkg::S_DUMP;
              end
            end
            default: begin
              // unused codes: no result, no state change
            end
          endcase
        end
      end
      dq_pkg::S_POP: begin
        strobe_d = 1'b1;
        last_d   = 1'b1;
        elem_d   = rd_q;
        state_d  = dq_pkg::S_IDLE;
      end
      dq_pkg::S_DUMP: begin
        // emit element cnt_q-1, fetch element cnt_q
        strobe_d = 1'b1;
        elem_d   = rd_q;
        rd_addr  = slot_of(front_q, cnt_q[IdxW-1:0]);
        if (cnt_q == occ_q) begin
          last_d  = 1'b1;
          state_d = dq_pkg::S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dq_pkg::S_IDLE;
      front_q  <= '0;
      occ_q    <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
      status_q <= dq_pkg::ST_OK;
      elem_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      occ_q    <= occ_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
      status_q <= status_d;
      elem_q   <= elem_d;
      last_q   <= last_d;
    end
  end

  // ring storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_i;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign busy_o        = (state_q != dq_pkg::S_IDLE);
  assign strobe_o      = strobe_q;
  assign status_o      = status_q;
  assign element_o     = elem_q;
  assign last_of_run_o = last_q;

  // occupancy never exceeds the ring size
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CapOcc)
    else $error("occupancy above capacity");

  // occupancy moves by at most one per cycle
  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |->
      (occ_q == $past(occ_q) + 1'b1 || occ_q == $past(occ_q) - 1'b1))
    else $error("occupancy jumped");

  // a pop in flight always ends with a single final result
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dq_pkg::S_POP) |=> (strobe_q && last_q && status_q == dq_pkg::ST_OK))
    else $error("pop result missing");

  // only a dump produces non-final results, and the ring is left alone meanwhile
  a_dump_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !last_q) |-> (state_q == dq_pkg::S_DUMP && $stable(occ_q)))
    else $error("non-final result outside dump");

  // the sequencer never leaves a dump without a final result
  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dq_pkg::S_DUMP && state_d == dq_pkg::S_IDLE) |=> (strobe_q && last_q))
    else $error("dump ended without last result");

endmodule

`default_nettype wire
